@@ hdl/ufts_pkg.sv @@
// Shared types, constants and helpers for the unicycle tracking step.
// Used by every module of the block; depends on nothing.
package ufts_pkg;

  localparam int TAB_LEN  = 24;
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int DIV_BITS = 31;
  localparam logic signed [33:0] CORDIC_K = 34'sd652032874;

  typedef enum logic [2:0] {
    REG_GAIN_X        = 3'd0,
    REG_GAIN_Y        = 3'd1,
    REG_OFFSET_B      = 3'd2,
    REG_INV_OFFSET_B  = 3'd3,
    REG_LINEAR_LIMIT  = 3'd4,
    REG_ANGULAR_LIMIT = 3'd5,
    REG_ERR_LIMIT_X   = 3'd6,
    REG_ERR_LIMIT_Y   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [23:0] gain_x;
    logic [23:0] gain_y;
    logic [15:0] offset_b;
    logic [31:0] inv_offset_b;
    logic [30:0] linear_limit;
    logic [30:0] angular_limit;
    logic [30:0] err_limit_x;
    logic [30:0] err_limit_y;
  } cfg_t;

  // one transaction after sin/cos, queued between front and back
  typedef struct packed {
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [31:0] ffx;
    logic signed [31:0] ffy;
    logic signed [33:0] c;
    logic signed [33:0] s;
  } work_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic signed [33:0] atan_angle(input int i);
    logic signed [33:0] a;
    case (i)
      0:  a = 34'sh020000000;
      1:  a = 34'sh012E4051E;
      2:  a = 34'sh009FB385B;
      3:  a = 34'sh0051111D4;
      4:  a = 34'sh0028B0D43;
      5:  a = 34'sh00145D7E1;
      6:  a = 34'sh000A2F61E;
      7:  a = 34'sh000517C55;
      8:  a = 34'sh00028BE53;
      9:  a = 34'sh000145F2F;
      10: a = 34'sh0000A2F98;
      11: a = 34'sh0000517CC;
      12: a = 34'sh000028BE6;
      13: a = 34'sh0000145F3;
      14: a = 34'sh00000A2FA;
      15: a = 34'sh00000517D;
      16: a = 34'sh0000028BE;
      17: a = 34'sh00000145F;
      18: a = 34'sh000000A30;
      19: a = 34'sh000000518;
      20: a = 34'sh00000028C;
      21: a = 34'sh000000146;
      22: a = 34'sh0000000A3;
      23: a = 34'sh000000051;
      default: a = '0;
    endcase
    return a;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = $signed(v[31:0]);
    end
    return r;
  endfunction

endpackage

@@ hdl/ufts_front.sv @@
// Front: accepts transactions, forms position differences and runs the
// pipelined CORDIC for sin/cos of the heading. Depends on ufts_pkg.
module ufts_front #(
  parameter int ITER = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_valid,
  output logic                s_ready,
  input  logic signed [31:0]  ref_x,
  input  logic signed [31:0]  ref_y,
  input  logic signed [31:0]  ff_vel_x,
  input  logic signed [31:0]  ff_vel_y,
  input  logic signed [31:0]  pose_x,
  input  logic signed [31:0]  pose_y,
  input  logic [15:0]         heading,
  output logic                push,
  output ufts_pkg::work_t     push_data,
  input  ufts_pkg::q_stat_t   q_stat
);
  import ufts_pkg::*;

  typedef struct packed {
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [31:0] ffx;
    logic signed [31:0] ffy;
  } pay_t;

  logic               vld  [0:ITER];
  logic signed [33:0] xs   [0:ITER];
  logic signed [33:0] ys   [0:ITER];
  logic signed [33:0] zs   [0:ITER];
  logic               flip [0:ITER];
  pay_t               pay  [0:ITER];

  logic        adv;
  logic [31:0] phase;
  logic        flip0;

  assign adv     = !(vld[ITER] && q_stat.full);
  assign s_ready = adv;
  assign push    = vld[ITER] && !q_stat.full;
  assign phase   = {heading, 16'h0000};
  assign flip0   = phase[31] ^ phase[30];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= ITER; k++) vld[k] <= 1'b0;
    end else if (adv) begin
      vld[0] <= s_valid;
      for (int k = 1; k <= ITER; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xs[0]      <= CORDIC_K;
      ys[0]      <= '0;
      zs[0]      <= 34'($signed({phase[31] ^ flip0, phase[30:0]}));
      flip[0]    <= flip0;
      pay[0].dx  <= 33'(ref_x) - 33'(pose_x);
      pay[0].dy  <= 33'(ref_y) - 33'(pose_y);
      pay[0].ffx <= ff_vel_x;
      pay[0].ffy <= ff_vel_y;
      for (int i = 0; i < ITER; i++) begin
        if (zs[i] >= 0) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - atan_angle(i);
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + atan_angle(i);
        end
        flip[i+1] <= flip[i];
        pay[i+1]  <= pay[i];
      end
    end
  end

  always_comb begin
    push_data.dx  = pay[ITER].dx;
    push_data.dy  = pay[ITER].dy;
    push_data.ffx = pay[ITER].ffx;
    push_data.ffy = pay[ITER].ffy;
    push_data.c   = flip[ITER] ? -xs[ITER] : xs[ITER];
    push_data.s   = flip[ITER] ? -ys[ITER] : ys[ITER];
  end

  assert property (@(posedge clk) disable iff (rst)
    !s_ready |-> (vld[ITER] && q_stat.full))
    else $error("front stalled without a full queue");
  assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("push into full queue");
  assert property (@(posedge clk) disable iff (rst)
    (vld[ITER] && q_stat.full) |=> vld[ITER])
    else $error("stalled transaction dropped");

endmodule

@@ hdl/ufts_queue.sv @@
// Short queue between front and back so each side stalls on its own.
// Depends on ufts_pkg.
module ufts_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ufts_pkg::work_t   push_data,
  input  logic              pop,
  output ufts_pkg::work_t   pop_data,
  output ufts_pkg::q_stat_t q_stat
);
  import ufts_pkg::*;

  work_t             mem [0:QDEPTH-1];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign q_stat.full  = (count == (QPTR_W+1)'(QDEPTH));
  assign q_stat.empty = (count == '0);
  assign pop_data     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  assert property (@(posedge clk) disable iff (rst) pop |-> !q_stat.empty)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count lost a push");
  assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W+1)'(QDEPTH))
    else $error("queue overfilled");

endmodule

@@ hdl/ufts_back.sv @@
// Back: offset-point error, feedback law, unicycle commands, limit scaling
// with a pipelined restoring divider and the output register. Uses ufts_pkg.
module ufts_back (
  input  logic               clk,
  input  logic               rst,
  input  ufts_pkg::cfg_t     cfg,
  input  ufts_pkg::work_t    q_data,
  input  ufts_pkg::q_stat_t  q_stat,
  output logic               pop,
  output logic               m_valid,
  input  logic               m_ready,
  output logic signed [31:0] linear_cmd,
  output logic signed [31:0] angular_cmd,
  output logic               was_scaled,
  output logic               abort
);
  import ufts_pkg::*;

  typedef struct packed {
    logic signed [31:0] v;
    logic signed [31:0] w;
    logic               gt;
    logic               lt;
    logic               need;
    logic               abort;
    logic [31:0]        den;
    logic [31:0]        rem;
    logic [DIV_BITS-1:0] nlo;
    logic [DIV_BITS-1:0] q;
  } div_t;

  logic adv;
  assign adv = !m_valid || m_ready;
  assign pop = adv && !q_stat.empty;

  // stage 1: offset-point error
  logic               v1;
  logic signed [33:0] ex1, ey1, c1, s1;
  logic signed [31:0] ffx1, ffy1;
  logic signed [50:0] bc, bs;
  assign bc = $signed({1'b0, cfg.offset_b}) * q_data.c;
  assign bs = $signed({1'b0, cfg.offset_b}) * q_data.s;

  // stage 2: abort test and feedback law
  logic               v2, ab2;
  logic signed [31:0] vdx2, vdy2;
  logic signed [33:0] c2, s2;
  logic signed [58:0] gxe, gye;
  logic signed [43:0] sx, sy;
  assign gxe = $signed({1'b0, cfg.gain_x}) * ex1;
  assign gye = $signed({1'b0, cfg.gain_y}) * ey1;
  assign sx  = 44'($signed(gxe[58:16])) + 44'(ffx1);
  assign sy  = 44'($signed(gye[58:16])) + 44'(ffy1);

  // stage 3: rotation products
  logic               v3, ab3;
  logic signed [65:0] pxc, pys, pyc, pxs;

  // stage 4: v and the w numerator
  logic               v4, ab4;
  logic signed [31:0] vv4, t4;
  logic signed [66:0] sumv, sumt;
  assign sumv = 67'(pxc) + 67'(pys);
  assign sumt = 67'(pyc) - 67'(pxs);

  // stage 5: w = t / b
  logic               v5, ab5;
  logic signed [31:0] vv5, ww5;
  logic signed [64:0] pw;
  assign pw = t4 * $signed({1'b0, cfg.inv_offset_b});

  // stage 6: magnitudes and limit test
  logic               v6, ab6, need6;
  logic signed [31:0] vv6, ww6;
  logic [31:0]        av6, aw6;

  // stage 7: cross products of the ratios
  logic               v7, ab7, need7;
  logic signed [31:0] vv7, ww7;
  logic [31:0]        av7, aw7;
  logic [62:0]        lhs7, rhs7;

  logic [62:0] num7;
  assign num7 = (lhs7 > rhs7) ? rhs7 : lhs7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0;
    end else if (adv) begin
      v1 <= pop; v2 <= v1; v3 <= v2; v4 <= v3;
      v5 <= v4; v6 <= v5; v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ex1  <= 34'(q_data.dx) - 34'($signed(bc[50:30]));
      ey1  <= 34'(q_data.dy) - 34'($signed(bs[50:30]));
      ffx1 <= q_data.ffx;
      ffy1 <= q_data.ffy;
      c1   <= q_data.c;
      s1   <= q_data.s;

      ab2  <= (ey1 > $signed({3'b000, cfg.err_limit_y}))
           || (ex1 > $signed({3'b000, cfg.err_limit_x}));
      vdx2 <= sat32(64'(sx));
      vdy2 <= sat32(64'(sy));
      c2   <= c1;
      s2   <= s1;

      ab3 <= ab2;
      pxc <= vdx2 * c2;
      pys <= vdy2 * s2;
      pyc <= vdy2 * c2;
      pxs <= vdx2 * s2;

      ab4 <= ab3;
      vv4 <= sat32(64'($signed(sumv[66:30])));
      t4  <= sat32(64'($signed(sumt[66:30])));

      ab5 <= ab4;
      vv5 <= vv4;
      ww5 <= sat32(64'($signed(pw[64:16])));

      ab6   <= ab5;
      vv6   <= vv5;
      ww6   <= ww5;
      av6   <= (vv5 < 0) ? 32'(-vv5) : 32'(vv5);
      aw6   <= (ww5 < 0) ? 32'(-ww5) : 32'(ww5);
      need6 <= ((vv5 < 0) ? 32'(-vv5) : 32'(vv5)) > {1'b0, cfg.linear_limit}
            || ((ww5 < 0) ? 32'(-ww5) : 32'(ww5)) > {1'b0, cfg.angular_limit};

      ab7   <= ab6;
      need7 <= need6;
      vv7   <= vv6;
      ww7   <= ww6;
      av7   <= av6;
      aw7   <= aw6;
      lhs7  <= av6 * cfg.angular_limit;
      rhs7  <= aw6 * cfg.linear_limit;
    end
  end

  // restoring divider, one quotient bit per stage
  logic vd [0:DIV_BITS];
  div_t dv [0:DIV_BITS];
  div_t dn [1:DIV_BITS];

  for (genvar j = 0; j < DIV_BITS; j++) begin : g_div
    logic [32:0] trial;
    logic        ge;
    assign trial = {dv[j].rem, dv[j].nlo[DIV_BITS-1-j]};
    assign ge    = trial >= {1'b0, dv[j].den};
    always_comb begin
      dn[j+1]     = dv[j];
      dn[j+1].rem = ge ? 32'(trial - {1'b0, dv[j].den}) : trial[31:0];
      dn[j+1].q   = {dv[j].q[DIV_BITS-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DIV_BITS; k++) vd[k] <= 1'b0;
    end else if (adv) begin
      vd[0] <= v7;
      for (int k = 1; k <= DIV_BITS; k++) vd[k] <= vd[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv[0].v     <= vv7;
      dv[0].w     <= ww7;
      dv[0].gt    <= lhs7 > rhs7;
      dv[0].lt    <= lhs7 < rhs7;
      dv[0].need  <= need7;
      dv[0].abort <= ab7;
      dv[0].den   <= (lhs7 > rhs7) ? av7 : aw7;
      dv[0].rem   <= num7[62:DIV_BITS];
      dv[0].nlo   <= num7[DIV_BITS-1:0];
      dv[0].q     <= '0;
      for (int k = 1; k <= DIV_BITS; k++) dv[k] <= dn[k];
    end
  end

  // output register
  div_t               df;
  logic signed [31:0] lin_lim, ang_lim, mq;
  assign df      = dv[DIV_BITS];
  assign lin_lim = $signed({1'b0, cfg.linear_limit});
  assign ang_lim = $signed({1'b0, cfg.angular_limit});
  assign mq      = $signed({1'b0, df.q});

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (adv) begin
      m_valid <= vd[DIV_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (df.abort) begin
        linear_cmd  <= '0;
        angular_cmd <= '0;
        was_scaled  <= 1'b0;
        abort       <= 1'b1;
      end else if (!df.need) begin
        linear_cmd  <= df.v;
        angular_cmd <= df.w;
        was_scaled  <= 1'b0;
        abort       <= 1'b0;
      end else begin
        was_scaled <= 1'b1;
        abort      <= 1'b0;
        if (df.gt) begin
          linear_cmd  <= (df.v > 0) ? lin_lim : -lin_lim;
          angular_cmd <= (df.w < 0) ? -mq : mq;
        end else if (df.lt) begin
          angular_cmd <= (df.w > 0) ? ang_lim : -ang_lim;
          linear_cmd  <= (df.v < 0) ? -mq : mq;
        end else begin
          linear_cmd  <= (df.v > 0) ? lin_lim : -lin_lim;
          angular_cmd <= (df.w > 0) ? ang_lim : -ang_lim;
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (m_valid && abort) |-> (linear_cmd == 0 && angular_cmd == 0 && !was_scaled))
    else $error("abort result carries a command");
  assert property (@(posedge clk) disable iff (rst)
    (m_valid && was_scaled) |-> (linear_cmd <= lin_lim && linear_cmd >= -lin_lim))
    else $error("scaled linear command beyond limit");
  assert property (@(posedge clk) disable iff (rst)
    (m_valid && was_scaled) |-> (angular_cmd <= ang_lim && angular_cmd >= -ang_lim))
    else $error("scaled angular command beyond limit");

endmodule

@@ hdl/unicycle_feedback_tracking_step.sv @@
// Top level of the unicycle offset-point tracking step: config registers,
// front (CORDIC), queue and back (control law, scaling). Uses ufts_pkg.
//
// channel  | dir | handshake                   | payload
// s_axis   | in  | s_axis_tvalid/s_axis_tready | tdata: ref_x ref_y ff_vel_x ff_vel_y
//          |     |                             |        pose_x pose_y heading
// m_axis   | out | m_axis_tvalid/m_axis_tready | tdata: linear_cmd angular_cmd
//          |     |                             | tuser: was_scaled abort
// cfg      | in  | cfg_we                      | cfg_addr, cfg_wdata
//
// One transaction per cycle sustained while m_axis_tready is high; the path
// has one CORDIC stage per iteration and one divider stage per quotient bit.
// rst is synchronous; it clears valid flags and loads register defaults.
// A stall on m_axis freezes the back pipeline, then the queue fills, then
// s_axis_tready is held low.
module unicycle_feedback_tracking_step #(
  parameter int SINCOS_ITER = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // ref_x[31:0] ref_y[63:32] ff_vel_x[95:64] ff_vel_y[127:96]
  // pose_x[159:128] pose_y[191:160] heading[207:192]
  input  logic [207:0]  s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // linear_cmd[31:0] angular_cmd[63:32]
  output logic [63:0]   m_axis_tdata,
  // was_scaled[0] abort[1]
  output logic [1:0]    m_axis_tuser,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_addr,
  input  logic [31:0]   cfg_wdata
);
  import ufts_pkg::*;

  cfg_t    cfg;
  work_t   push_data, pop_data;
  q_stat_t q_stat;
  logic    push, pop;
  logic signed [31:0] linear_cmd, angular_cmd;
  logic    was_scaled, abort;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_x        <= 24'd33423;
      cfg.gain_y        <= 24'd33423;
      cfg.offset_b      <= 16'd9830;
      cfg.inv_offset_b  <= 32'd436907;
      cfg.linear_limit  <= 31'd78643;
      cfg.angular_limit <= 31'd102892;
      cfg.err_limit_x   <= 31'd65536;
      cfg.err_limit_y   <= 31'd65536;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_GAIN_X:        cfg.gain_x        <= cfg_wdata[23:0];
        REG_GAIN_Y:        cfg.gain_y        <= cfg_wdata[23:0];
        REG_OFFSET_B:      cfg.offset_b      <= cfg_wdata[15:0];
        REG_INV_OFFSET_B:  cfg.inv_offset_b  <= cfg_wdata;
        REG_LINEAR_LIMIT:  cfg.linear_limit  <= cfg_wdata[30:0];
        REG_ANGULAR_LIMIT: cfg.angular_limit <= cfg_wdata[30:0];
        REG_ERR_LIMIT_X:   cfg.err_limit_x   <= cfg_wdata[30:0];
        REG_ERR_LIMIT_Y:   cfg.err_limit_y   <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  ufts_front #(.ITER(SINCOS_ITER)) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_valid   (s_axis_tvalid),
    .s_ready   (s_axis_tready),
    .ref_x     ($signed(s_axis_tdata[31:0])),
    .ref_y     ($signed(s_axis_tdata[63:32])),
    .ff_vel_x  ($signed(s_axis_tdata[95:64])),
    .ff_vel_y  ($signed(s_axis_tdata[127:96])),
    .pose_x    ($signed(s_axis_tdata[159:128])),
    .pose_y    ($signed(s_axis_tdata[191:160])),
    .heading   (s_axis_tdata[207:192]),
    .push      (push),
    .push_data (push_data),
    .q_stat    (q_stat)
  );

  ufts_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  ufts_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_data      (pop_data),
    .q_stat      (q_stat),
    .pop         (pop),
    .m_valid     (m_axis_tvalid),
    .m_ready     (m_axis_tready),
    .linear_cmd  (linear_cmd),
    .angular_cmd (angular_cmd),
    .was_scaled  (was_scaled),
    .abort       (abort)
  );

  assign m_axis_tdata = {angular_cmd, linear_cmd};
  assign m_axis_tuser = {abort, was_scaled};

endmodule

@@ tb/sv/unicycle_feedback_tracking_step_tb.sv @@
// Testbench for unicycle_feedback_tracking_step: random and directed poses
// checked against a behavioral predictor in a small scoreboard class.
// Depends on ufts_pkg and the block's RTL.
`timescale 1ns / 100ps

module unicycle_feedback_tracking_step_tb;
  import ufts_pkg::*;

  localparam int ITER        = 16;
  localparam int LATENCY     = ITER + 42;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct {
    logic signed [31:0] ref_x, ref_y, ffx, ffy, px, py;
    logic [15:0] heading;
  } pose_item_t;

  typedef struct {
    logic signed [31:0] lin, ang;
    logic scaled, abort;
  } cmd_t;

  typedef struct {
    longint unsigned gain_x, gain_y, offset_b, inv_b, lin_lim, ang_lim, elim_x, elim_y;
  } settings_t;

  class cmd_scoreboard;
    cmd_t pending[$];
    settings_t cfg;
    int mismatches;
    int checked;
    int aborts;
    int scaled_cnt;

    function void set_reg(reg_idx_t idx, longint unsigned val);
      case (idx)
        REG_GAIN_X:        cfg.gain_x = val & 64'hFFFFFF;
        REG_GAIN_Y:        cfg.gain_y = val & 64'hFFFFFF;
        REG_OFFSET_B:      cfg.offset_b = val & 64'hFFFF;
        REG_INV_OFFSET_B:  cfg.inv_b = val & 64'hFFFFFFFF;
        REG_LINEAR_LIMIT:  cfg.lin_lim = val & 64'h7FFFFFFF;
        REG_ANGULAR_LIMIT: cfg.ang_lim = val & 64'h7FFFFFFF;
        REG_ERR_LIMIT_X:   cfg.elim_x = val & 64'h7FFFFFFF;
        REG_ERR_LIMIT_Y:   cfg.elim_y = val & 64'h7FFFFFFF;
        default: ;
      endcase
    endfunction

    function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint angle_tab(int i);
      longint t[24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};
      return t[i];
    endfunction

    function void rotate(logic [15:0] hd, output longint c, output longint s);
      logic [31:0] p;
      logic [1:0] q;
      bit flip;
      longint x, y, z, dx, dy;
      p = {hd, 16'h0};
      q = p[31:30];
      flip = (q == 2'd1 || q == 2'd2);
      if (flip) p = p - 32'h80000000;
      x = 652032874;
      y = 0;
      z = longint'($signed(p));
      for (int i = 0; i < ITER; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= angle_tab(i);
        end else begin
          x += dx; y -= dy; z += angle_tab(i);
        end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function cmd_t predict(pose_item_t it);
      cmd_t r;
      longint c, s, ex, ey, vdx, vdy, v, w, t, av, aw, lhs, rhs, m;
      rotate(it.heading, c, s);
      ex = longint'(it.ref_x) - longint'(it.px) - ((longint'(cfg.offset_b) * c) >>> 30);
      ey = longint'(it.ref_y) - longint'(it.py) - ((longint'(cfg.offset_b) * s) >>> 30);
      r = '{0, 0, 1'b0, 1'b0};
      if (ey > longint'(cfg.elim_y) || ex > longint'(cfg.elim_x)) begin
        r.abort = 1'b1;
        return r;
      end
      vdx = clip32(longint'(it.ffx) + ((longint'(cfg.gain_x) * ex) >>> 16));
      vdy = clip32(longint'(it.ffy) + ((longint'(cfg.gain_y) * ey) >>> 16));
      v = clip32((vdx * c + vdy * s) >>> 30);
      t = clip32((vdy * c - vdx * s) >>> 30);
      w = clip32((t * longint'(cfg.inv_b)) >>> 16);
      av = v < 0 ? -v : v;
      aw = w < 0 ? -w : w;
      if (av > longint'(cfg.lin_lim) || aw > longint'(cfg.ang_lim)) begin
        r.scaled = 1'b1;
        lhs = av * longint'(cfg.ang_lim);
        rhs = aw * longint'(cfg.lin_lim);
        if (lhs > rhs) begin
          m = rhs / av;
          v = v > 0 ? longint'(cfg.lin_lim) : -longint'(cfg.lin_lim);
          w = w < 0 ? -m : m;
        end else if (lhs < rhs) begin
          m = lhs / aw;
          w = w > 0 ? longint'(cfg.ang_lim) : -longint'(cfg.ang_lim);
          v = v < 0 ? -m : m;
        end else begin
          v = v > 0 ? longint'(cfg.lin_lim) : -longint'(cfg.lin_lim);
          w = w > 0 ? longint'(cfg.ang_lim) : -longint'(cfg.ang_lim);
        end
      end
      r.lin = v[31:0];
      r.ang = w[31:0];
      return r;
    endfunction

    function void note_pose(pose_item_t it);
      pending.push_back(predict(it));
    endfunction

    function void check_cmd(cmd_t got);
      cmd_t exp_cmd;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected command transaction lin=%0d ang=%0d",
                                       got.lin, got.ang);
        return;
      end
      exp_cmd = pending.pop_front();
      checked++;
      if (exp_cmd.abort) aborts++;
      if (exp_cmd.scaled) scaled_cnt++;
      if (got.lin !== exp_cmd.lin || got.ang !== exp_cmd.ang ||
          got.scaled !== exp_cmd.scaled || got.abort !== exp_cmd.abort) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch #%0d: exp lin=%0d ang=%0d sc=%0b ab=%0b",
                    "  got lin=%0d ang=%0d sc=%0b ab=%0b"},
                   checked, exp_cmd.lin, exp_cmd.ang, exp_cmd.scaled, exp_cmd.abort,
                   got.lin, got.ang, got.scaled, got.abort);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [207:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;

  cmd_scoreboard sb = new();
  bit idle_on = 1'b1;
  longint cycles = 0;
  int sent = 0;

  unicycle_feedback_tracking_step #(.SINCOS_ITER(ITER)) i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("unicycle_feedback_tracking_step_tb: errors");
      $finish;
    end
  end

  // output side: sample at rising edge, change ready at falling edge
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_cmd('{$signed(m_axis_tdata[31:0]), $signed(m_axis_tdata[63:32]),
                     m_axis_tuser[0], m_axis_tuser[1]});
  end

  initial begin
    int gap;
    gap = 0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (gap > 0) begin
        gap--;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 4) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, longint unsigned val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val[31:0];
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // valid stays high between back-to-back transactions, except for random idle gaps while idle_on; drain drops it
  task automatic send_pose(pose_item_t it);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {it.heading, it.py, it.px, it.ffy, it.ffx, it.ref_y, it.ref_x};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_pose(it);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic logic signed [31:0] near(logic signed [31:0] base, int span);
    return base + $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  // mostly tracking poses near the reference; sometimes anything goes
  function automatic pose_item_t rand_pose(int mode);
    pose_item_t it;
    it.heading = 16'($urandom());
    it.ref_x = $urandom();
    it.ref_y = $urandom();
    it.ffx = $urandom();
    it.ffy = $urandom();
    if (mode == 0) begin
      it.px = near(it.ref_x, 90000);
      it.py = near(it.ref_y, 90000);
      it.ffx = $signed($urandom_range(0, 400000)) - 200000;
      it.ffy = $signed($urandom_range(0, 400000)) - 200000;
    end else if (mode == 1) begin
      it.px = it.ref_x + $signed($urandom_range(0, 2000000));
      it.py = it.ref_y + $signed($urandom_range(0, 2000000));
    end else begin
      it.px = $urandom();
      it.py = $urandom();
    end
    return it;
  endfunction

  task automatic random_phase(int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 9);
      send_pose(rand_pose(r < 6 ? 0 : (r < 8 ? 1 : 2)));
    end
  endtask

  task automatic write_all(longint unsigned gx, longint unsigned gy, longint unsigned b,
                           longint unsigned ib, longint unsigned ll, longint unsigned al,
                           longint unsigned ex, longint unsigned ey);
    write_reg(REG_GAIN_X, gx);
    write_reg(REG_GAIN_Y, gy);
    write_reg(REG_OFFSET_B, b);
    write_reg(REG_INV_OFFSET_B, ib);
    write_reg(REG_LINEAR_LIMIT, ll);
    write_reg(REG_ANGULAR_LIMIT, al);
    write_reg(REG_ERR_LIMIT_X, ex);
    write_reg(REG_ERR_LIMIT_Y, ey);
  endtask

  initial begin
    pose_item_t it;
    logic [15:0] hds[8] = '{16'h0000, 16'h3FFF, 16'h4000, 16'h7FFF,
                            16'h8000, 16'hBFFF, 16'hC000, 16'hFFFF};
    sb.cfg = '{33423, 33423, 9830, 436907, 78643, 102892, 65536, 65536};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: quadrant edges of the heading, zero error, extremes, aborts
    foreach (hds[k]) begin
      it = '{0, 0, 0, 0, 0, 0, hds[k]};
      send_pose(it);
    end
    send_pose('{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'h1234});
    send_pose('{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                32'sh80000000, 32'sh80000000, 16'hFFFF});
    send_pose('{32'sh7FFFFFFF, 0, 0, 0, 32'sh80000000, 0, 16'h0000});
    send_pose('{0, 32'sh7FFFFFFF, 0, 0, 0, 32'sh80000000, 16'h0000});
    send_pose('{0, 0, 32'sh00100000, 0, 0, 0, 16'h0000});
    send_pose('{0, 0, 0, 32'sh00100000, 0, 0, 16'h0000});
    send_pose('{0, 0, 32'sh80000000, 32'sh7FFFFFFF, 0, 0, 16'h2000});
    send_pose('{32'sh80000000, 32'sh80000000, 0, 0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'h8000});
    drain();

    // limits of 1 with zero gains and a zero inverse offset: w is always zero, so scaled commands saturate v
    write_all(0, 0, 1, 0, 1, 1, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_pose('{0, 0, 32'sh00010000, 0, 0, 0, 16'h0000});
    send_pose('{0, 0, 32'sh00000002, 32'sh00000002, 0, 0, 16'h0000});
    drain();

    write_all(33423, 33423, 9830, 436907, 78643, 102892, 65536, 65536);
    random_phase(250);
    drain();

    write_all(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 32'hFFFFFFFF, 31'h7FFFFFFF,
              31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF);
    random_phase(150);
    drain();

    write_all(0, 1, 1, 0, 1, 1, 0, 0);
    random_phase(100);
    drain();

    write_all($urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF),
              $urandom_range(1, 16'hFFFF), $urandom(), $urandom_range(1, 31'h7FFFFFFF),
              $urandom_range(1, 200000), $urandom_range(0, 31'h7FFFFFFF),
              $urandom_range(0, 31'h7FFFFFFF));
    random_phase(150);
    drain();

    write_all(33423, 40000, 20000, 214748, 78643, 102892, 200000, 200000);
    random_phase(100);
    idle_on = 1'b0;
    random_phase(80);
    drain();

    $display("%0d poses sent, %0d commands checked (%0d aborted, %0d scaled)",
             sent, sb.checked, sb.aborts, sb.scaled_cnt);
    $display("six register settings including all-zero and all-max extremes");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("unicycle_feedback_tracking_step_tb: clean");
    end else begin
      $display("%0d mismatches, %0d commands still pending", sb.mismatches,
               sb.pending.size());
      $display("unicycle_feedback_tracking_step_tb: errors");
    end
    $finish;
  end
endmodule
